### hw/rtl/olte_pkg.sv
// shared types, constants and codes of the ordered list table engine
`default_nettype none

package olte_pkg;

    localparam int DEPTH   = 256;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int CMD_W   = 4;
    localparam int POS_W   = 9;
    localparam int STAT_W  = 2;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND   = 4'd0,
        CMD_INSERT   = 4'd1,
        CMD_GET      = 4'd2,
        CMD_SET      = 4'd3,
        CMD_DEL_SWAP = 4'd4,
        CMD_DEL_ORD  = 4'd5,
        CMD_REMOVE   = 4'd6,
        CMD_CONTAINS = 4'd7,
        CMD_CLEAR    = 4'd8,
        CMD_TRUNCATE = 4'd9
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GET,
        S_DSWAP,
        S_INS,
        S_DORD,
        S_RM_RD,
        S_RM_CMP,
        S_RM_MV,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] item_value;
    } cmd_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               found;
        logic [CNT_W-1:0]   length;
        logic [STAT_W-1:0]  status;
    } rsp_word_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } mem_req_t;

endpackage

`default_nettype wire

### hw/rtl/olte_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module olte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/olte_engine.sv
// command sequencer: count register and read-modify-write walks over the entry ram
`default_nettype none

module olte_engine (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire olte_pkg::cmd_word_t        cmd_word,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output olte_pkg::rsp_word_t             res_word,
    output olte_pkg::mem_req_t              mem_req,
    input  wire logic [olte_pkg::VALUE_W-1:0] mem_rdata
);

    olte_pkg::state_t               state_reg, state_next;
    logic [olte_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [olte_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [olte_pkg::VALUE_W-1:0]   val_reg, val_next;
    logic [olte_pkg::CNT_W-1:0]     ptr_reg, ptr_next;
    logic                           pend_reg, pend_next;
    logic [olte_pkg::IDX_W-1:0]     waddr_reg, waddr_next;
    logic [olte_pkg::VALUE_W-1:0]   rv_reg, rv_next;
    logic                           found_reg, found_next;
    olte_pkg::status_t              st_reg, st_next;

    logic [olte_pkg::CNT_W-1:0]     count_dec, count_inc, ptr_dec, ptr_inc, in_pos;

    assign count_dec = count_reg - olte_pkg::CNT_W'(1);
    assign count_inc = count_reg + olte_pkg::CNT_W'(1);
    assign ptr_dec   = ptr_reg - olte_pkg::CNT_W'(1);
    assign ptr_inc   = ptr_reg + olte_pkg::CNT_W'(1);
    assign in_pos    = cmd_word.position + olte_pkg::CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olte_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        ptr_reg   <= ptr_next;
        waddr_reg <= waddr_next;
        rv_reg    <= rv_next;
        found_reg <= found_next;
        st_reg    <= st_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        ptr_next   = ptr_reg;
        pend_next  = pend_reg;
        waddr_next = waddr_reg;
        rv_next    = rv_reg;
        found_next = found_reg;
        st_next    = st_reg;
        mem_req    = '0;
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            olte_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    pos_next   = cmd_word.position;
                    val_next   = cmd_word.item_value;
                    st_next    = olte_pkg::ST_OK;
                    found_next = 1'b0;
                    rv_next    = '0;
                    pend_next  = 1'b0;
                    state_next = olte_pkg::S_DONE;
                    unique case (olte_pkg::cmd_t'(cmd_word.cmd))
                        olte_pkg::CMD_APPEND:
                        begin
                            if (count_reg == olte_pkg::FULL_COUNT)
                            begin
                                st_next = olte_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = count_reg[olte_pkg::IDX_W-1:0];
                                mem_req.wdata = cmd_word.item_value;
                                count_next    = count_inc;
                            end
                        end
                        olte_pkg::CMD_INSERT:
                        begin
                            if (cmd_word.position > count_reg)
                            begin
                                st_next = olte_pkg::ST_BAD;
                            end
                            else if (count_reg == olte_pkg::FULL_COUNT)
                            begin
                                st_next = olte_pkg::ST_FULL;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = olte_pkg::S_INS;
                            end
                        end
                        olte_pkg::CMD_GET:
                        begin
                            if (cmd_word.position >= count_reg)
                            begin
                                st_next = olte_pkg::ST_BAD;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = cmd_word.position[olte_pkg::IDX_W-1:0];
                                state_next    = olte_pkg::S_GET;
                            end
                        end
                        olte_pkg::CMD_SET:
                        begin
                            if (cmd_word.position >= count_reg)
                            begin
                                st_next = olte_pkg::ST_BAD;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = cmd_word.position[olte_pkg::IDX_W-1:0];
                                mem_req.wdata = cmd_word.item_value;
                            end
                        end
                        olte_pkg::CMD_DEL_SWAP:
                        begin
                            if (cmd_word.position >= count_reg)
                            begin
                                st_next = olte_pkg::ST_BAD;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = count_dec[olte_pkg::IDX_W-1:0];
                                count_next    = count_dec;
                                state_next    = olte_pkg::S_DSWAP;
                            end
                        end
                        olte_pkg::CMD_DEL_ORD:
                        begin
                            if (cmd_word.position >= count_reg)
                            begin
                                st_next = olte_pkg::ST_BAD;
                            end
                            else
                            begin
                                count_next = count_dec;
                                ptr_next   = in_pos;
                                state_next = olte_pkg::S_DORD;
                            end
                        end
                        olte_pkg::CMD_REMOVE:
                        begin
                            if (cmd_word.item_value != '0)
                            begin
                                ptr_next   = '0;
                                state_next = olte_pkg::S_RM_RD;
                            end
                        end
                        olte_pkg::CMD_CONTAINS:
                        begin
                            ptr_next   = '0;
                            state_next = olte_pkg::S_SCAN;
                        end
                        olte_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        olte_pkg::CMD_TRUNCATE:
                        begin
                            if (cmd_word.position > count_reg)
                            begin
                                st_next = olte_pkg::ST_BAD;
                            end
                            else
                            begin
                                count_next = cmd_word.position;
                            end
                        end
                        default:
                        begin
                            st_next = olte_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            olte_pkg::S_GET:
            begin
                rv_next    = mem_rdata;
                state_next = olte_pkg::S_DONE;
            end
            olte_pkg::S_DSWAP:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg[olte_pkg::IDX_W-1:0];
                mem_req.wdata = mem_rdata;
                state_next    = olte_pkg::S_DONE;
            end
            olte_pkg::S_INS:
            begin
                // walk down from the top, each word written one slot higher
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = waddr_reg;
                    mem_req.wdata = mem_rdata;
                end
                if (ptr_reg > pos_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_dec[olte_pkg::IDX_W-1:0];
                    waddr_next    = ptr_reg[olte_pkg::IDX_W-1:0];
                    ptr_next      = ptr_dec;
                    pend_next     = 1'b1;
                end
                else if (!pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pos_reg[olte_pkg::IDX_W-1:0];
                    mem_req.wdata = val_reg;
                    count_next    = count_inc;
                    state_next    = olte_pkg::S_DONE;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            olte_pkg::S_DORD:
            begin
                // walk up from the hole, each word written one slot lower
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = waddr_reg;
                    mem_req.wdata = mem_rdata;
                end
                if (ptr_reg <= count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg[olte_pkg::IDX_W-1:0];
                    waddr_next    = ptr_dec[olte_pkg::IDX_W-1:0];
                    ptr_next      = ptr_inc;
                    pend_next     = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = olte_pkg::S_DONE;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            olte_pkg::S_RM_RD:
            begin
                if (ptr_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg[olte_pkg::IDX_W-1:0];
                    state_next    = olte_pkg::S_RM_CMP;
                end
                else
                begin
                    state_next = olte_pkg::S_DONE;
                end
            end
            olte_pkg::S_RM_CMP:
            begin
                if (mem_rdata == val_reg)
                begin
                    found_next    = 1'b1;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = count_dec[olte_pkg::IDX_W-1:0];
                    count_next    = count_dec;
                    state_next    = olte_pkg::S_RM_MV;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = olte_pkg::S_RM_RD;
                end
            end
            olte_pkg::S_RM_MV:
            begin
                // last word fills the hole, same slot checked again
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg[olte_pkg::IDX_W-1:0];
                mem_req.wdata = mem_rdata;
                state_next    = olte_pkg::S_RM_RD;
            end
            olte_pkg::S_SCAN:
            begin
                if (pend_reg && (mem_rdata == val_reg))
                begin
                    found_next = 1'b1;
                    pend_next  = 1'b0;
                    state_next = olte_pkg::S_DONE;
                end
                else if (ptr_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg[olte_pkg::IDX_W-1:0];
                    ptr_next      = ptr_inc;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = olte_pkg::S_DONE;
                end
            end
            olte_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = olte_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = olte_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_word.read_value = rv_reg;
        res_word.found      = found_reg;
        res_word.length     = count_reg;
        res_word.status     = st_reg;
    end

    // count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= olte_pkg::FULL_COUNT)
    else $error("entry count above table size");

    // the shifting walks never read and write one slot in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("read and write of the same slot in one cycle");

    // a failed command carries neither a read word nor a found flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == olte_pkg::S_DONE && st_reg != olte_pkg::ST_OK)
        |-> (rv_reg == '0 && !found_reg))
    else $error("failed command with read word or found flag");

    // a held result does not change while it waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_word)))
    else $error("pending result changed");

endmodule

`default_nettype wire

### hw/rtl/ordered_list_table_engine.sv
// top level of the ordered list table engine: sequencer, entry ram and response register
`default_nettype none

// ordered list table engine: keeps a dense list of up to 256 32-bit values
// in a single-port-read, single-port-write ram plus a 9-bit count, and
// answers every command word with exactly one response word carrying the
// new length and a status (ok, bad index or length, list full). one command
// is worked on at a time; the command channel reopens as soon as the
// response has moved into the output register, so a new command is taken
// while the previous response still waits downstream. walks over the ram
// move one word per cycle:
//   insert at p: the words from p upward each move one slot higher
//   delete ordered at p: the words above p each move one slot lower
//   contains: one compare per cycle, ending at the first match
//   remove value: each match is filled by the last word; a zero value
//   removes nothing
// append, set, clear, truncate, get, delete swap and any failed command
// need no walk.
// the single ram read port, with its registered read, sets every walk.
// entries are never cleared: a slot is only read after it was written, so
// reset takes effect at once and there is no clearing pass.

module ordered_list_table_engine (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire olte_pkg::cmd_word_t cmd_word,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output olte_pkg::rsp_word_t      rsp_word
);

    // sequencer to output register
    logic                        res_valid;
    logic                        res_ready;
    olte_pkg::rsp_word_t         res_word;

    // ram port
    olte_pkg::mem_req_t          mem_req;
    logic [olte_pkg::VALUE_W-1:0] mem_rdata;

    // response register
    logic                        rsp_valid_reg, rsp_valid_next;
    olte_pkg::rsp_word_t         rsp_word_reg, rsp_word_next;

    olte_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    olte_ram #(
        .WIDTH (olte_pkg::VALUE_W),
        .DEPTH (olte_pkg::DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // output register frees the sequencer while downstream stalls
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = res_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

`default_nettype wire
